// ----- hw/rtl/cdq_pkg.sv -----
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants of the circular deque: mode and status codes,
// word width and the result beat layout.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int WORD_W    = 32;
    localparam int MODE_W    = 3;
    localparam int STATUS_W  = 2;

    localparam logic [MODE_W-1:0] MODE_NONE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped;
        logic [STATUS_W-1:0]      status;
        logic signed [WORD_W-1:0] head;
        logic signed [WORD_W-1:0] tail;
        logic                     empty;
        logic                     full;
    } res_t;

endpackage

// ----- hw/rtl/cdq_ring.sv -----
// ----------------------------------------------------------------------------
// cdq_ring
// Ring store of the deque: one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
module cdq_ring #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [IDX_W-1:0]                  wr_addr,
    input  logic signed [cdq_pkg::WORD_W-1:0] wr_data,
    input  logic                              rd_en,
    input  logic [IDX_W-1:0]                  rd_addr,
    output logic signed [cdq_pkg::WORD_W-1:0] rd_data
);
    import cdq_pkg::*;

    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/circular_deque.sv -----
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of signed words in a ring store. Each input beat pushes
// at either end, pops from either end or only queries; each gives one
// result beat with the popped word, status, end words and empty/full flags.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   mode, push_value
//   out      output     out_valid / out_stall popped_value, status,
//                                             head_value, tail_value,
//                                             is_empty, is_full
//
// push, query, failed operations and a pop that empties the queue finish on
// the accepted beat itself; a pop that leaves entries passes through a read
// state that waits on the ring store read port for the new end word.
// a finished result waits in the output register while the next beat is
// taken; a second finished result behind a stalled output stalls the input.
// reset clears the indices, count and cached end words; no clearing pass.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [cdq_pkg::MODE_W-1:0]          mode,
    input  logic signed [cdq_pkg::WORD_W-1:0]   push_value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [cdq_pkg::WORD_W-1:0]   popped_value,
    output logic [cdq_pkg::STATUS_W-1:0]        status,
    output logic signed [cdq_pkg::WORD_W-1:0]   head_value,
    output logic signed [cdq_pkg::WORD_W-1:0]   tail_value,
    output logic                                is_empty,
    output logic                                is_full
);
    import cdq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_WAIT = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [IDX_W-1:0]         head_idx_reg, head_idx_next;
    logic [IDX_W-1:0]         tail_idx_reg, tail_idx_next;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic signed [WORD_W-1:0] head_val_reg, head_val_next;
    logic signed [WORD_W-1:0] tail_val_reg, tail_val_next;
    logic                     patch_head_reg, patch_head_next;
    res_t                     res_reg, res_next;
    res_t                     out_reg, out_next;
    logic                     out_valid_reg, out_valid_next;

    res_t                     res_now;
    logic                     accept;
    logic                     out_free;
    logic                     need_read;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_addr;
    logic signed [WORD_W-1:0] rd_data;

    function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    cdq_ring #(
        .DEPTH (DEPTH),
        .IDX_W (IDX_W)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (push_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    // operation on the accepted beat, or the end word refresh from the ring read
    always_comb
    begin
        head_idx_next   = head_idx_reg;
        tail_idx_next   = tail_idx_reg;
        occ_next        = occ_reg;
        head_val_next   = head_val_reg;
        tail_val_next   = tail_val_reg;
        patch_head_next = patch_head_reg;
        need_read       = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        rd_en           = 1'b0;
        rd_addr         = '0;
        res_now.popped  = EMPTY_WORD;
        res_now.status  = ST_OK;

        if (accept)
        begin
            unique case (mode) inside
                MODE_PUSH_FRONT, MODE_PUSH_REAR:
                begin
                    if (occ_reg == FULL_OCC)
                    begin
                        res_now.status = ST_OVERFLOW;
                    end
                    else if (occ_reg == '0)
                    begin
                        head_idx_next = '0;
                        tail_idx_next = '0;
                        head_val_next = push_value;
                        tail_val_next = push_value;
                        wr_en         = 1'b1;
                        wr_addr       = '0;
                        occ_next      = OCC_W'(1);
                    end
                    else if (mode == MODE_PUSH_FRONT)
                    begin
                        head_idx_next = idx_down(head_idx_reg);
                        head_val_next = push_value;
                        wr_en         = 1'b1;
                        wr_addr       = idx_down(head_idx_reg);
                        occ_next      = occ_reg + 1'b1;
                    end
                    else
                    begin
                        tail_idx_next = idx_up(tail_idx_reg);
                        tail_val_next = push_value;
                        wr_en         = 1'b1;
                        wr_addr       = idx_up(tail_idx_reg);
                        occ_next      = occ_reg + 1'b1;
                    end
                end
                MODE_POP_FRONT, MODE_POP_REAR:
                begin
                    if (occ_reg == '0)
                    begin
                        res_now.status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        occ_next = occ_reg - 1'b1;
                        if (mode == MODE_POP_FRONT)
                        begin
                            res_now.popped = head_val_reg;
                        end
                        else
                        begin
                            res_now.popped = tail_val_reg;
                        end
                        if (occ_reg == OCC_W'(1))
                        begin
                            head_idx_next = '0;
                            tail_idx_next = '0;
                        end
                        else if (mode == MODE_POP_FRONT)
                        begin
                            head_idx_next   = idx_up(head_idx_reg);
                            rd_en           = 1'b1;
                            rd_addr         = idx_up(head_idx_reg);
                            need_read       = 1'b1;
                            patch_head_next = 1'b1;
                        end
                        else
                        begin
                            tail_idx_next   = idx_down(tail_idx_reg);
                            rd_en           = 1'b1;
                            rd_addr         = idx_down(tail_idx_reg);
                            need_read       = 1'b1;
                            patch_head_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (state_reg == S_READ)
        begin
            if (patch_head_reg)
            begin
                head_val_next = rd_data;
            end
            else
            begin
                tail_val_next = rd_data;
            end
        end

        res_now.empty = (occ_next == '0);
        res_now.full  = (occ_next == FULL_OCC);
        res_now.head  = res_now.empty ? EMPTY_WORD : head_val_next;
        res_now.tail  = res_now.empty ? EMPTY_WORD : tail_val_next;
    end

    // result sequencing
    always_comb
    begin
        state_next     = state_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (need_read)
                    begin
                        res_next   = res_now;
                        state_next = S_READ;
                    end
                    else if (out_free)
                    begin
                        out_next       = res_now;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        res_next   = res_now;
                        state_next = S_WAIT;
                    end
                end
            end
            S_READ:
            begin
                res_next = res_reg;
                if (patch_head_reg)
                begin
                    res_next.head = rd_data;
                end
                else
                begin
                    res_next.tail = rd_data;
                end
                if (out_free)
                begin
                    out_next       = res_next;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_idx_reg   <= '0;
            tail_idx_reg   <= '0;
            occ_reg        <= '0;
            head_val_reg   <= EMPTY_WORD;
            tail_val_reg   <= EMPTY_WORD;
            patch_head_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_idx_reg   <= head_idx_next;
            tail_idx_reg   <= tail_idx_next;
            occ_reg        <= occ_next;
            head_val_reg   <= head_val_next;
            tail_val_reg   <= tail_val_next;
            patch_head_reg <= patch_head_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = out_reg.popped;
    assign status       = out_reg.status;
    assign head_value   = out_reg.head;
    assign tail_value   = out_reg.tail;
    assign is_empty     = out_reg.empty;
    assign is_full      = out_reg.full;

endmodule

// ----- hw/rtl/cdq_check.sv -----
// ----------------------------------------------------------------------------
// cdq_check
// Port-level checks of the circular deque, bound to the top level.
// ----------------------------------------------------------------------------
module cdq_check (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                out_valid,
    input logic                                out_stall,
    input logic signed [cdq_pkg::WORD_W-1:0]   popped_value,
    input logic [cdq_pkg::STATUS_W-1:0]        status,
    input logic signed [cdq_pkg::WORD_W-1:0]   head_value,
    input logic signed [cdq_pkg::WORD_W-1:0]   tail_value,
    input logic                                is_empty,
    input logic                                is_full
);
    import cdq_pkg::*;

    a_not_empty_and_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(is_empty && is_full))
        else $error("result beat both empty and full");

    a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_empty) |-> (head_value == EMPTY_WORD && tail_value == EMPTY_WORD))
        else $error("empty result carries end words");

    a_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_UNDERFLOW) |-> (is_empty && popped_value == EMPTY_WORD))
        else $error("underflow on a non-empty queue");

    a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_OVERFLOW) |-> (is_full && popped_value == EMPTY_WORD))
        else $error("overflow on a queue that is not full");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(popped_value) && $stable(status)))
        else $error("stalled result beat changed");

endmodule

bind circular_deque cdq_check u_cdq_check (.*);

// ----- verif/circular_deque_test.sv -----
// ----------------------------------------------------------------------------
// circular_deque_test
// Self-checking bench for the circular deque. A short directed sequence
// covers the empty queue, underflow, the spare mode codes, pushes and pops at
// both ends and index wrap. Biased random runs then fill the queue, drain it
// and hit overflow. A mirror of the deque predicts every result beat and
// checks it in order. Sender and receiver idle at random in two phases.
// One long receiver hold-off backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
class deque_mirror;

    logic signed [cdq_pkg::WORD_W-1:0] ring [cdq_pkg::DEPTH_DEF];
    int unsigned                       front_at;
    int unsigned                       rear_at;
    int unsigned                       fill;
    cdq_pkg::res_t                     due [$];
    int unsigned                       mismatches;

    function new();
        front_at   = 0;
        rear_at    = 0;
        fill       = 0;
        mismatches = 0;
    endfunction

    function void note_op(logic [cdq_pkg::MODE_W-1:0] op,
                          logic signed [cdq_pkg::WORD_W-1:0] word);
        cdq_pkg::res_t want;
        want.popped = cdq_pkg::EMPTY_WORD;
        want.status = cdq_pkg::ST_OK;
        case (op) inside
            cdq_pkg::MODE_PUSH_FRONT, cdq_pkg::MODE_PUSH_REAR:
            begin
                if (fill == cdq_pkg::DEPTH_DEF)
                    want.status = cdq_pkg::ST_OVERFLOW;
                else if (fill == 0)
                begin
                    front_at = 0;
                    rear_at  = 0;
                    ring[0]  = word;
                    fill     = 1;
                end
                else if (op == cdq_pkg::MODE_PUSH_FRONT)
                begin
                    front_at       = (front_at == 0) ? cdq_pkg::DEPTH_DEF - 1 : front_at - 1;
                    ring[front_at] = word;
                    fill++;
                end
                else
                begin
                    rear_at       = (rear_at == cdq_pkg::DEPTH_DEF - 1) ? 0 : rear_at + 1;
                    ring[rear_at] = word;
                    fill++;
                end
            end
            cdq_pkg::MODE_POP_FRONT, cdq_pkg::MODE_POP_REAR:
            begin
                if (fill == 0)
                    want.status = cdq_pkg::ST_UNDERFLOW;
                else
                begin
                    if (op == cdq_pkg::MODE_POP_FRONT)
                    begin
                        want.popped = ring[front_at];
                        front_at    = (front_at == cdq_pkg::DEPTH_DEF - 1) ? 0 : front_at + 1;
                    end
                    else
                    begin
                        want.popped = ring[rear_at];
                        rear_at     = (rear_at == 0) ? cdq_pkg::DEPTH_DEF - 1 : rear_at - 1;
                    end
                    fill--;
                    if (fill == 0)
                    begin
                        front_at = 0;
                        rear_at  = 0;
                    end
                end
            end
            default:
                ;
        endcase
        want.empty = (fill == 0);
        want.full  = (fill == cdq_pkg::DEPTH_DEF);
        want.head  = want.empty ? cdq_pkg::EMPTY_WORD : ring[front_at];
        want.tail  = want.empty ? cdq_pkg::EMPTY_WORD : ring[rear_at];
        due.push_back(want);
    endfunction

    function void check_result(cdq_pkg::res_t got);
        cdq_pkg::res_t want;
        if (due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result beat: popped=%0d status=%0d head=%0d tail=%0d",
                         got.popped, got.status, got.head, got.tail);
            return;
        end
        want = due.pop_front();
        if (got.popped !== want.popped || got.status !== want.status ||
            got.head !== want.head || got.tail !== want.tail ||
            got.empty !== want.empty || got.full !== want.full)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("expected popped=%0d status=%0d head=%0d tail=%0d empty=%0b full=%0b",
                         want.popped, want.status, want.head, want.tail, want.empty, want.full);
                $display("actual   popped=%0d status=%0d head=%0d tail=%0d empty=%0b full=%0b",
                         got.popped, got.status, got.head, got.tail, got.empty, got.full);
            end
        end
    endfunction

endclass

module circular_deque_test;

    import cdq_pkg::*;

    localparam int unsigned STALL_LIMIT = 3000;
    localparam int unsigned HOLD_CYCLES = 150;
    localparam int unsigned TAIL_CYCLES = 20;
    localparam int unsigned PHASE_ITEMS = 212;

    localparam logic [MODE_W-1:0] MODE_SPARE_A = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_B = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_C = 3'd7;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [MODE_W-1:0]        mode;
    logic signed [WORD_W-1:0] push_value;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [WORD_W-1:0] popped_value;
    logic [STATUS_W-1:0]      status;
    logic signed [WORD_W-1:0] head_value;
    logic signed [WORD_W-1:0] tail_value;
    logic                     is_empty;
    logic                     is_full;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_req      = 1'b0;
    int unsigned quiet_cycles  = 0;

    deque_mirror mirror = new();

    circular_deque dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .status       (status),
        .head_value   (head_value),
        .tail_value   (tail_value),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // scoreboard hooks and watchdog, all on the rising edge
    always @(posedge clk)
    begin
        res_t got;
        if (rst_n && in_valid && !in_stall)
            mirror.note_op(mode, push_value);
        if (rst_n && out_valid && !out_stall)
        begin
            got.popped = popped_value;
            got.status = status;
            got.head   = head_value;
            got.tail   = tail_value;
            got.empty  = is_empty;
            got.full   = is_full;
            mirror.check_result(got);
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("[circular_deque] ERROR");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    function automatic logic signed [WORD_W-1:0] rand_word();
        case ($urandom_range(9))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return EMPTY_WORD;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [MODE_W-1:0] pick_mode(int unsigned push_pct);
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 2)
            return MODE_NONE;
        if (roll < 4)
            return MODE_W'($urandom_range(MODE_SPARE_C, MODE_SPARE_A));
        if (roll < 4 + push_pct)
            return $urandom_range(1) ? MODE_PUSH_FRONT : MODE_PUSH_REAR;
        return $urandom_range(1) ? MODE_POP_FRONT : MODE_POP_REAR;
    endfunction

    // entered and left at a falling edge
    task automatic send_op(logic [MODE_W-1:0] op, logic signed [WORD_W-1:0] word);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        push_value <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // runs of pushes or pops so the queue swings between empty and full
    task automatic run_random(int unsigned count);
        int unsigned left;
        int unsigned run_len;
        int unsigned push_pct;
        left = count;
        while (left > 0)
        begin
            run_len = $urandom_range(40, 8);
            if (run_len > left)
                run_len = left;
            case ($urandom_range(2))
                0:       push_pct = 80;
                1:       push_pct = 48;
                default: push_pct = 20;
            endcase
            repeat (run_len)
                send_op(pick_mode(push_pct), rand_word());
            left -= run_len;
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_NONE;
        push_value = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_op(MODE_NONE, 32'sh1234_5678);
        send_op(MODE_SPARE_A, rand_word());
        send_op(MODE_POP_FRONT, rand_word());
        send_op(MODE_POP_REAR, rand_word());
        send_op(MODE_PUSH_FRONT, 32'sh7fff_ffff);
        send_op(MODE_PUSH_REAR, 32'sh8000_0000);
        send_op(MODE_PUSH_FRONT, '0);
        send_op(MODE_PUSH_REAR, EMPTY_WORD);
        send_op(MODE_SPARE_B, rand_word());
        send_op(MODE_POP_REAR, rand_word());
        send_op(MODE_POP_FRONT, rand_word());
        send_op(MODE_POP_FRONT, rand_word());
        send_op(MODE_SPARE_C, rand_word());
        send_op(MODE_POP_REAR, rand_word());
        send_op(MODE_POP_REAR, rand_word());

        send_idle_pct = 31;
        recv_idle_pct = 59;
        run_random(PHASE_ITEMS);
        send_idle_pct = 59;
        recv_idle_pct = 31;
        run_random(PHASE_ITEMS);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req      = 1'b1;
        run_random(PHASE_ITEMS);
        in_valid <= 1'b0;

        while (mirror.due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mirror.mismatches == 0)
            $display("[circular_deque] OK");
        else
            $display("[circular_deque] ERROR");
        $finish;
    end

endmodule
